[hdl/linear_recurrence_matrix_power_mod_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the matrix power block
// Clocked on aclk, disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef LINEAR_RECURRENCE_MATRIX_POWER_MOD_ASSERT_SVH
`define LINEAR_RECURRENCE_MATRIX_POWER_MOD_ASSERT_SVH

// same-cycle implication
`define LRMP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lrmp assertion failed");

// next-cycle implication
`define LRMP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lrmp assertion failed");

`endif

[hdl/lrmp_pkg.sv]
// ---------------------------------------------------------------------------
// lrmp_pkg
// Types, constants and helpers shared by the matrix power block.
// ---------------------------------------------------------------------------
package lrmp_pkg;

    localparam int ELEM_W        = 14;
    localparam int TERM_W        = 63;
    localparam int ORDER_W       = 5;
    localparam int IN_TDATA_W    = 72;
    localparam int OUT_TDATA_W   = 16;
    localparam int PROD_W        = 2 * ELEM_W;
    localparam int BARRETT_SHIFT = 41;
    localparam int RECIP_W       = 28;

    localparam logic [ELEM_W-1:0]  MODULUS   = 14'd10007;
    localparam logic [RECIP_W-1:0] BARRETT_R =
        RECIP_W'((64'd1 << BARRETT_SHIFT) / 64'd10007);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_DECIDE,
        ST_MUL,
        ST_DRAIN,
        ST_COPY,
        ST_STEP,
        ST_SUM,
        ST_FIN,
        ST_OUT
    } st_t;

    typedef enum logic {
        MODE_ACC,
        MODE_SQR
    } mul_mode_t;

    typedef struct packed {
        logic vld;
        logic last;
    } mac_tag_t;

    typedef struct packed {
        logic acc;
        logic pw;
        logic sc;
    } mem_we_t;

    function automatic logic [ELEM_W-1:0] mod_add(input logic [ELEM_W-1:0] a,
                                                  input logic [ELEM_W-1:0] b);
        logic [ELEM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MODULUS}) begin
            s = s - {1'b0, MODULUS};
        end
        return s[ELEM_W-1:0];
    endfunction

endpackage

[hdl/lrmp_mac.sv]
// ---------------------------------------------------------------------------
// lrmp_mac
// Pipelined modular multiply-accumulate: one product per cycle, Barrett
// reduction of each product, running sum modulo 10007 closed by last.
// ---------------------------------------------------------------------------
module lrmp_mac (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lrmp_pkg::mac_tag_t            in_tag,
    input  logic [lrmp_pkg::ELEM_W-1:0]   in_a,
    input  logic [lrmp_pkg::ELEM_W-1:0]   in_b,
    output logic                          out_vld,
    output logic [lrmp_pkg::ELEM_W-1:0]   out_data
);
    import lrmp_pkg::*;

    localparam int BQ_W = PROD_W + RECIP_W;
    localparam int Q_W  = ELEM_W + 1;

    mac_tag_t                tag1_reg, tag2_reg, tag3_reg;
    logic [PROD_W-1:0]       prod_reg, x2_reg;
    logic [BQ_W-1:0]         bq_reg;
    logic [Q_W-1:0]          rm_reg, rm_next;
    logic [Q_W-1:0]          q;
    logic [ELEM_W-1:0]       red;
    logic [ELEM_W-1:0]       sum;
    logic [ELEM_W-1:0]       acc_reg, acc_next;
    logic                    out_vld_reg;
    logic [ELEM_W-1:0]       out_data_reg;

    always_comb begin
        q       = bq_reg[BARRETT_SHIFT +: Q_W];
        rm_next = Q_W'(x2_reg - PROD_W'(q) * PROD_W'(MODULUS));
        if (rm_reg >= Q_W'(MODULUS)) begin
            red = ELEM_W'(rm_reg - Q_W'(MODULUS));
        end else begin
            red = ELEM_W'(rm_reg);
        end
        sum      = mod_add(acc_reg, red);
        acc_next = acc_reg;
        if (tag3_reg.vld) begin
            acc_next = tag3_reg.last ? '0 : sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg    <= '0;
            tag2_reg    <= '0;
            tag3_reg    <= '0;
            acc_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            tag1_reg    <= in_tag;
            tag2_reg    <= tag1_reg;
            tag3_reg    <= tag2_reg;
            acc_reg     <= acc_next;
            out_vld_reg <= tag3_reg.vld && tag3_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= in_a * in_b;
        bq_reg       <= BQ_W'(prod_reg) * BQ_W'(BARRETT_R);
        x2_reg       <= prod_reg;
        rm_reg       <= rm_next;
        out_data_reg <= sum;
    end

    assign out_vld  = out_vld_reg;
    assign out_data = out_data_reg;

endmodule

[hdl/lrmp_mats.sv]
// ---------------------------------------------------------------------------
// lrmp_mats
// Matrix stores: running product, repeated square (two read ports) and
// product buffer, each with one write port and registered reads.
// ---------------------------------------------------------------------------
module lrmp_mats #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                          aclk,
    input  lrmp_pkg::mem_we_t             we,
    input  logic [AW-1:0]                 acc_wa,
    input  logic [lrmp_pkg::ELEM_W-1:0]   acc_wd,
    input  logic [AW-1:0]                 acc_ra,
    output logic [lrmp_pkg::ELEM_W-1:0]   acc_rd,
    input  logic [AW-1:0]                 pw_wa,
    input  logic [lrmp_pkg::ELEM_W-1:0]   pw_wd,
    input  logic [AW-1:0]                 pw_ra_a,
    output logic [lrmp_pkg::ELEM_W-1:0]   pw_rd_a,
    input  logic [AW-1:0]                 pw_ra_b,
    output logic [lrmp_pkg::ELEM_W-1:0]   pw_rd_b,
    input  logic [AW-1:0]                 sc_wa,
    input  logic [lrmp_pkg::ELEM_W-1:0]   sc_wd,
    input  logic [AW-1:0]                 sc_ra,
    output logic [lrmp_pkg::ELEM_W-1:0]   sc_rd
);
    import lrmp_pkg::*;

    logic [ELEM_W-1:0] acc_mem [DEPTH];
    logic [ELEM_W-1:0] pw_mem  [DEPTH];
    logic [ELEM_W-1:0] sc_mem  [DEPTH];

    always_ff @(posedge aclk) begin
        if (we.acc) begin
            acc_mem[acc_wa] <= acc_wd;
        end
        acc_rd <= acc_mem[acc_ra];
    end

    always_ff @(posedge aclk) begin
        if (we.pw) begin
            pw_mem[pw_wa] <= pw_wd;
        end
        pw_rd_a <= pw_mem[pw_ra_a];
        pw_rd_b <= pw_mem[pw_ra_b];
    end

    always_ff @(posedge aclk) begin
        if (we.sc) begin
            sc_mem[sc_wa] <= sc_wd;
        end
        sc_rd <= sc_mem[sc_ra];
    end

endmodule

[hdl/linear_recurrence_matrix_power_mod.sv]
// ---------------------------------------------------------------------------
// linear_recurrence_matrix_power_mod
// Twice the first-column sum of the k-by-k companion matrix raised to n-1,
// modulo 10007, by square-and-multiply over stored matrices.
//
//   channel  dir  tdata fields (low bit up)                 width
//   s_       in   term_index[62:0], order[67:63], zero pad    72
//   m_       out  term_value[13:0], zero pad                  16
//
// The number of matrix products is at most two per bit of n-1; the single
// modular multiply-accumulate unit takes one term per cycle.
// Reset: control only; the matrix stores hold nothing valid until written.
// s_tready is high only when idle; the result register holds a beat until
// taken while the next item is already accepted.
// ---------------------------------------------------------------------------
`include "linear_recurrence_matrix_power_mod_assert.svh"

module linear_recurrence_matrix_power_mod #(
    parameter int MAX_ORDER = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lrmp_pkg::IN_TDATA_W-1:0]    s_tdata,  // term_index, order
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lrmp_pkg::OUT_TDATA_W-1:0]   m_tdata   // term_value
);
    import lrmp_pkg::*;

    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CW    = $clog2(MAX_ORDER + 1);

    function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] row,
                                                input logic [IW-1:0] col);
        return AW'(row) * AW'(MAX_ORDER) + AW'(col);
    endfunction

    function automatic logic [ELEM_W-1:0] dbl(input logic [ELEM_W-1:0] v);
        return mod_add(v, v);
    endfunction

    st_t                 state_reg, state_next;
    mul_mode_t           mode_reg, mode_next;
    logic [CW-1:0]       dim_reg, dim_next, dim_m1, dim_in;
    logic [TERM_W-1:0]   e_reg, e_next, n_in;
    logic [ORDER_W-1:0]  order_in;
    logic [IW-1:0]       r_reg, r_next, c_reg, c_next, t_reg, t_next;
    logic [IW-1:0]       wr_r_reg, wr_r_next, wr_c_reg, wr_c_next;
    mac_tag_t            iss_reg, iss_next;
    logic                cp_vld_reg, cp_vld_next;
    logic [AW-1:0]       cp_addr_reg, cp_addr_next;
    logic                sum_vld_reg, sum_vld_next;
    logic [ELEM_W-1:0]   sum_reg, sum_next;
    logic                out_vld_reg, out_vld_next;
    logic [ELEM_W-1:0]   out_data_reg, out_data_next;

    logic r_last, c_last, t_last, wr_r_last, wr_c_last;
    logic in_fire, out_free;

    mem_we_t             mem_we;
    logic [AW-1:0]       acc_wa, acc_ra, pw_wa, pw_ra_a, pw_ra_b, sc_wa, sc_ra;
    logic [ELEM_W-1:0]   acc_wd, acc_rd, pw_wd, pw_rd_a, pw_rd_b, sc_rd;
    logic [ELEM_W-1:0]   mac_a;
    logic                mac_out_vld;
    logic [ELEM_W-1:0]   mac_out_data;

    assign n_in     = s_tdata[TERM_W-1:0];
    assign order_in = s_tdata[TERM_W +: ORDER_W];

    always_comb begin
        if (order_in == '0) begin
            dim_in = CW'(1);
        end else if (int'(order_in) > MAX_ORDER) begin
            dim_in = CW'(MAX_ORDER);
        end else begin
            dim_in = CW'(order_in);
        end
    end

    assign dim_m1    = dim_reg - CW'(1);
    assign r_last    = CW'(r_reg) == dim_m1;
    assign c_last    = CW'(c_reg) == dim_m1;
    assign t_last    = CW'(t_reg) == dim_m1;
    assign wr_r_last = CW'(wr_r_reg) == dim_m1;
    assign wr_c_last = CW'(wr_c_reg) == dim_m1;

    assign s_tready = state_reg == ST_IDLE;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) state_next = ST_INIT;
            end
            ST_INIT: begin
                if (r_last && c_last) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = (e_reg == '0) ? ST_SUM : ST_MUL;
            end
            ST_MUL: begin
                if (r_last && c_last && t_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (mac_out_vld && wr_r_last && wr_c_last) state_next = ST_COPY;
            end
            ST_COPY: begin
                if (r_last && c_last) state_next = ST_STEP;
            end
            ST_STEP: begin
                if (mode_reg == MODE_SQR) begin
                    state_next = ST_DECIDE;
                end else if (e_reg[TERM_W-1:1] != '0) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (r_last) state_next = ST_FIN;
            end
            ST_FIN: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        mode_next     = mode_reg;
        dim_next      = dim_reg;
        e_next        = e_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        t_next        = t_reg;
        sum_next      = sum_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_data_next = out_data_reg;

        wr_r_next = wr_r_reg;
        wr_c_next = wr_c_reg;
        if (mac_out_vld) begin
            wr_c_next = wr_c_last ? '0 : wr_c_reg + IW'(1);
            if (wr_c_last) wr_r_next = wr_r_last ? '0 : wr_r_reg + IW'(1);
        end

        if (sum_vld_reg) begin
            sum_next = mod_add(sum_reg, acc_rd);
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    dim_next = dim_in;
                    e_next   = (n_in == '0) ? '0 : n_in - TERM_W'(1);
                    r_next   = '0;
                    c_next   = '0;
                    t_next   = '0;
                end
            end
            ST_INIT, ST_COPY: begin
                c_next = c_last ? '0 : c_reg + IW'(1);
                if (c_last) r_next = r_last ? '0 : r_reg + IW'(1);
            end
            ST_DECIDE: begin
                if (e_reg == '0) begin
                    sum_next = '0;
                end else if (e_reg[0]) begin
                    mode_next = MODE_ACC;
                end else begin
                    mode_next = MODE_SQR;
                    e_next    = e_reg >> 1;
                end
            end
            ST_MUL: begin
                t_next = t_last ? '0 : t_reg + IW'(1);
                if (t_last) c_next = c_last ? '0 : c_reg + IW'(1);
                if (t_last && c_last) r_next = r_last ? '0 : r_reg + IW'(1);
            end
            ST_STEP: begin
                if (mode_reg == MODE_ACC) begin
                    e_next = e_reg >> 1;
                    if (e_reg[TERM_W-1:1] != '0) begin
                        mode_next = MODE_SQR;
                    end else begin
                        sum_next = '0;
                    end
                end
            end
            ST_SUM: begin
                r_next = r_last ? '0 : r_reg + IW'(1);
            end
            ST_OUT: begin
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_data_next = dbl(sum_reg);
                end
            end
            default: begin
            end
        endcase

        iss_next.vld  = state_reg == ST_MUL;
        iss_next.last = t_last;
        cp_vld_next   = state_reg == ST_COPY;
        cp_addr_next  = cell_addr(r_reg, c_reg);
        sum_vld_next  = state_reg == ST_SUM;

        acc_ra  = (state_reg == ST_SUM) ? cell_addr(r_reg, '0) : cell_addr(r_reg, t_reg);
        pw_ra_a = cell_addr(r_reg, t_reg);
        pw_ra_b = cell_addr(t_reg, c_reg);
        sc_ra   = cell_addr(r_reg, c_reg);

        mem_we.acc = (state_reg == ST_INIT) || (cp_vld_reg && mode_reg == MODE_ACC);
        mem_we.pw  = (state_reg == ST_INIT) || (cp_vld_reg && mode_reg == MODE_SQR);
        mem_we.sc  = mac_out_vld;

        if (state_reg == ST_INIT) begin
            acc_wa = cell_addr(r_reg, c_reg);
            pw_wa  = cell_addr(r_reg, c_reg);
            acc_wd = ELEM_W'(r_reg == c_reg);
            if (r_reg == '0) begin
                pw_wd = ELEM_W'(c_reg != '0);
            end else begin
                pw_wd = ELEM_W'((CW'(c_reg) + CW'(1)) == CW'(r_reg));
            end
        end else begin
            acc_wa = cp_addr_reg;
            pw_wa  = cp_addr_reg;
            acc_wd = sc_rd;
            pw_wd  = sc_rd;
        end
        sc_wa = cell_addr(wr_r_reg, wr_c_reg);
    end

    assign mac_a = (mode_reg == MODE_ACC) ? acc_rd : pw_rd_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_ACC;
            e_reg       <= '0;
            r_reg       <= '0;
            c_reg       <= '0;
            t_reg       <= '0;
            wr_r_reg    <= '0;
            wr_c_reg    <= '0;
            iss_reg     <= '0;
            cp_vld_reg  <= 1'b0;
            sum_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            e_reg       <= e_next;
            r_reg       <= r_next;
            c_reg       <= c_next;
            t_reg       <= t_next;
            wr_r_reg    <= wr_r_next;
            wr_c_reg    <= wr_c_next;
            iss_reg     <= iss_next;
            cp_vld_reg  <= cp_vld_next;
            sum_vld_reg <= sum_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        dim_reg      <= dim_next;
        cp_addr_reg  <= cp_addr_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
    end

    lrmp_mats #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mats (
        .aclk    (aclk),
        .we      (mem_we),
        .acc_wa  (acc_wa),
        .acc_wd  (acc_wd),
        .acc_ra  (acc_ra),
        .acc_rd  (acc_rd),
        .pw_wa   (pw_wa),
        .pw_wd   (pw_wd),
        .pw_ra_a (pw_ra_a),
        .pw_rd_a (pw_rd_a),
        .pw_ra_b (pw_ra_b),
        .pw_rd_b (pw_rd_b),
        .sc_wa   (sc_wa),
        .sc_wd   (mac_out_data),
        .sc_ra   (sc_ra),
        .sc_rd   (sc_rd)
    );

    lrmp_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_tag   (iss_reg),
        .in_a     (mac_a),
        .in_b     (pw_rd_b),
        .out_vld  (mac_out_vld),
        .out_data (mac_out_data)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

    `LRMP_ASSERT_NOW(a_mac_only_in_product, mac_out_vld, (state_reg == ST_MUL) || (state_reg == ST_DRAIN))
    `LRMP_ASSERT_NOW(a_no_store_write_in_mul, state_reg == ST_MUL, !mem_we.acc && !mem_we.pw)
    `LRMP_ASSERT_NOW(a_mac_reduced, mac_out_vld, mac_out_data < MODULUS)
    `LRMP_ASSERT_NEXT(a_accept_starts_init, s_tvalid && s_tready, state_reg == ST_INIT)

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for linear_recurrence_matrix_power_mod
// Streams (term index, order) beats into the block and checks every term value
// against a matrix-power predictor of its own. Directed corner cases come
// first, then a receiver hold-off that fills the block, then random beats.
// Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ORDER_CAP    = 16;
    localparam int RANDOM_ITEMS = 85;
    localparam int HOLD_CYCLES  = 3000;
    localparam int TAIL_CYCLES  = 64;
    localparam int STALL_LIMIT  = 2000000;

    class term_scoreboard;
        bit [13:0] acc_m [ORDER_CAP][ORDER_CAP];
        bit [13:0] pow_m [ORDER_CAP][ORDER_CAP];
        bit [13:0] tmp_m [ORDER_CAP][ORDER_CAP];
        bit [13:0] pending_terms[$];
        int        errors;
        int        mismatches;

        // acc = acc * pow when into_acc is set, else pow = pow * pow
        function void mat_product(bit into_acc, int dim);
            longint unsigned s;
            for (int r = 0; r < dim; r++) begin
                for (int c = 0; c < dim; c++) begin
                    s = 0;
                    for (int t = 0; t < dim; t++) begin
                        if (into_acc) begin
                            s = s + acc_m[r][t] * pow_m[t][c];
                        end else begin
                            s = s + pow_m[r][t] * pow_m[t][c];
                        end
                    end
                    tmp_m[r][c] = 14'(s % lrmp_pkg::MODULUS);
                end
            end
            for (int r = 0; r < dim; r++) begin
                for (int c = 0; c < dim; c++) begin
                    if (into_acc) begin
                        acc_m[r][c] = tmp_m[r][c];
                    end else begin
                        pow_m[r][c] = tmp_m[r][c];
                    end
                end
            end
        endfunction

        function bit [13:0] term_of(bit [62:0] term_index, bit [4:0] order);
            int              dim;
            bit [62:0]       exp_left;
            longint unsigned s;
            dim = (order == 0) ? 1 : (order > ORDER_CAP) ? ORDER_CAP : int'(order);
            exp_left = (term_index == 0) ? 63'd0 : term_index - 63'd1;
            for (int r = 0; r < dim; r++) begin
                for (int c = 0; c < dim; c++) begin
                    acc_m[r][c] = (r == c) ? 14'd1 : 14'd0;
                    if (r == 0) begin
                        pow_m[r][c] = (c == 0) ? 14'd0 : 14'd1;
                    end else begin
                        pow_m[r][c] = (c + 1 == r) ? 14'd1 : 14'd0;
                    end
                end
            end
            while (exp_left != 0) begin
                if (exp_left[0]) begin
                    mat_product(1'b1, dim);
                end
                exp_left = exp_left >> 1;
                if (exp_left != 0) begin
                    mat_product(1'b0, dim);
                end
            end
            s = 0;
            for (int r = 0; r < dim; r++) begin
                s = s + acc_m[r][0];
            end
            s = (2 * (s % lrmp_pkg::MODULUS)) % lrmp_pkg::MODULUS;
            return 14'(s);
        endfunction

        function void note_request(bit [62:0] term_index, bit [4:0] order);
            pending_terms.push_back(term_of(term_index, order));
        endfunction

        function void check_term(bit [13:0] got);
            bit [13:0] want;
            if (pending_terms.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected term value %0d", got);
                end
            end else begin
                want = pending_terms.pop_front();
                if (got !== want) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("term_value mismatch: expected %0d, got %0d", want, got);
                    end
                end
            end
        endfunction
    endclass

    logic                              aclk;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [lrmp_pkg::IN_TDATA_W-1:0]   s_tdata;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [lrmp_pkg::OUT_TDATA_W-1:0]  m_tdata;

    term_scoreboard sb = new();
    bit             no_idle;
    bit             hold_req;

    linear_recurrence_matrix_power_mod i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 200);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input bit [62:0] term_index, input bit [4:0] order);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {4'b0, order, term_index};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        sb.note_request(term_index, order);
        @(negedge aclk);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready   = 1'b1;
                stall_left = pick_gap();
            end
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready) begin
                sb.check_term(m_tdata[13:0]);
            end
        end
    end

    // watchdog on cycles without any beat
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        bit [62:0] term_index;
        bit [4:0]  order;
        int        w;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        no_idle  = 1'b0;
        hold_req = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        send_item(63'd0, 5'd3);
        send_item(63'd1, 5'd1);
        send_item(63'd1, 5'd16);
        send_item(63'd2, 5'd1);
        send_item(63'd5, 5'd1);
        send_item(63'd2, 5'd16);
        send_item(63'd3, 5'd16);
        send_item(63'd10, 5'd0);
        send_item(63'd10, 5'd31);
        send_item(63'd7, 5'd17);
        send_item({63{1'b1}}, 5'd1);
        send_item({63{1'b1}}, 5'd2);
        send_item({63{1'b1}}, 5'd3);
        send_item({63{1'b1}}, 5'd16);
        send_item(63'd1 << 62, 5'd4);
        send_item(63'd12345, 5'd5);
        send_item(63'd100, 5'd8);

        // hold the receiver off and offer six beats without idling so that the input stalls
        hold_req = 1'b1;
        no_idle  = 1'b1;
        for (int i = 0; i < 6; i++) begin
            send_item(63'($urandom_range(1, 50)), 5'($urandom_range(1, 3)));
        end
        no_idle = 1'b0;

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 20 == 0) begin
                no_idle = ($urandom_range(0, 2) == 0);
            end
            term_index = 63'({$urandom, $urandom});
            if ($urandom_range(0, 99) < 85) begin
                order = 5'($urandom_range(0, 3));
                w     = $urandom_range(0, 63);
            end else begin
                order = 5'($urandom_range(4, 31));
                w     = $urandom_range(0, 3);
            end
            if (w < 63) begin
                term_index = term_index & ((63'd1 << w) - 63'd1);
            end
            send_item(term_index, order);
        end
        s_tvalid = 1'b0;
        s_tdata  = '0;

        while (sb.pending_terms.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.pending_terms.size() != 0) begin
            sb.errors++;
        end

        if (sb.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
